>>> sv/cud_pkg.sv
// Shared widths and handshake types for the CPU usage decay block.
package cud_pkg;

    localparam int LA_W    = 20;              // load average register
    localparam int LOAD_W  = LA_W + 1;        // load factor, twice the load average
    localparam int USE_W   = 8;               // usage estimate
    localparam int NICE_W  = 6;
    localparam int SLEEP_W = 16;
    localparam int PRIO_W  = 9;
    localparam int PROD_W  = LOAD_W + USE_W;  // load times usage
    localparam int DEN_W   = LOAD_W + 1;      // load plus scale, scale shift up to 16
    localparam int CNT_W   = $clog2(PROD_W);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - PRIO_W - USE_W - SLEEP_W;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } cud_div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
        logic [DEN_W-1:0]  rem;
    } cud_div_rsp_t;

endpackage

>>> sv/cud_div.sv
// Shared restoring divider, one quotient bit per cycle.
module cud_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cud_pkg::cud_div_req_t req,
    output cud_pkg::cud_div_rsp_t rsp
);

    logic [cud_pkg::DEN_W-1:0]  rem_reg;
    logic [cud_pkg::DEN_W-1:0]  den_reg;
    logic [cud_pkg::PROD_W-1:0] num_reg;
    logic [cud_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [cud_pkg::DEN_W:0]    trial;
    logic [cud_pkg::DEN_W:0]    diff;
    logic                       q_bit;
    logic [cud_pkg::DEN_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[cud_pkg::PROD_W-1]};
        diff     = trial - {1'b0, den_reg};
        q_bit    = (trial >= {1'b0, den_reg});
        rem_next = q_bit ? diff[cud_pkg::DEN_W-1:0] : trial[cud_pkg::DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            num_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= '0;
                num_reg  <= req.num;
                den_reg  <= req.den;
                cnt_reg  <= cud_pkg::CNT_W'(cud_pkg::PROD_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[cud_pkg::PROD_W-2:0], q_bit};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> sv/cpu_usage_decay_top.sv
// Top level of the CPU usage decay block: sequencer, load register and output stage.
//
// One process record is taken at a time and its result is held in an output register,
// so the next record can be accepted while the previous result waits. The shared
// bit-serial divider gives one quotient bit per cycle over the 29-bit product. A non-zero
// priority weight costs one division for the load factor; each decay round is a loop
// check, a multiply and a divide. Function 0 takes one decay; function 1 takes up to 255
// decay rounds.
module cpu_usage_decay_top
#(
    parameter int SCALE_SHIFT = 11
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // cfg_data: load_average [19:0]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cud_pkg::LA_W-1:0]       cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // priority_weight [7:0], estimated_use [15:8], raw_use [23:16],
    // nice_value [29:24], sleep_time [45:30], zero [47:46]
    input  logic [cud_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func [0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // priority_value [8:0], new_estimated_use [16:9], new_sleep_time [32:17], zero [39:33]
    output logic [cud_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [cud_pkg::DEN_W-1:0] SCALE_ONE = cud_pkg::DEN_W'(1) << SCALE_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LF_DIV,
        ST_LF_WAIT,
        ST_CHECK,
        ST_LOOP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    logic [cud_pkg::LA_W-1:0]       load_avg_reg;
    logic                           func_reg;
    logic [cud_pkg::USE_W-1:0]      weight_reg;
    logic [cud_pkg::USE_W-1:0]      est_reg;
    logic [cud_pkg::USE_W-1:0]      raw_reg;
    logic [cud_pkg::NICE_W-1:0]     nice_reg;
    logic [cud_pkg::SLEEP_W-1:0]    sleep_reg;
    logic [cud_pkg::LOAD_W-1:0]     load_reg;
    logic [cud_pkg::USE_W-1:0]      use_reg;
    logic [cud_pkg::PROD_W-1:0]     prod_reg;
    logic [cud_pkg::PRIO_W-1:0]     prio_reg;
    logic                           div_started_reg;
    logic                           out_valid_reg;
    logic [cud_pkg::OUT_DATA_W-1:0] out_data_reg;

    cud_pkg::cud_div_req_t          div_req;
    cud_pkg::cud_div_rsp_t          div_rsp;

    logic                           in_accept;
    logic                           out_free;
    logic [cud_pkg::PROD_W-1:0]     prod_calc;
    logic [cud_pkg::LOAD_W+2:0]     load_x5;
    logic [cud_pkg::USE_W-1:0]      quot8;
    logic signed [cud_pkg::PRIO_W:0] prio_sum;
    logic [cud_pkg::PRIO_W-1:0]     prio_val;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign prod_calc = {{cud_pkg::USE_W{1'b0}}, load_reg}
                     * {{cud_pkg::LOAD_W{1'b0}}, use_reg};
    assign load_x5   = {load_reg, 2'b00} + {3'b000, load_reg};
    assign quot8     = div_rsp.quot[cud_pkg::USE_W-1:0];
    assign prio_sum  = $signed({2'b00, quot8})
                     + $signed({{(cud_pkg::PRIO_W + 1 - cud_pkg::NICE_W)
                                 {nice_reg[cud_pkg::NICE_W-1]}},
                                nice_reg});
    assign prio_val  = prio_sum[cud_pkg::PRIO_W] ? '0 : prio_sum[cud_pkg::PRIO_W-1:0];

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = {{cud_pkg::USE_W{1'b0}}, load_reg};
        div_req.den   = {{(cud_pkg::DEN_W - cud_pkg::USE_W){1'b0}}, weight_reg};
        if (state_reg == ST_LF_DIV)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == ST_DIV && !div_started_reg)
        begin
            div_req.start = 1'b1;
            div_req.num   = prod_reg;
            div_req.den   = {1'b0, load_reg} + SCALE_ONE;
        end
    end

    cud_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_avg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            load_avg_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= 1'b0;
            weight_reg      <= '0;
            est_reg         <= '0;
            raw_reg         <= '0;
            nice_reg        <= '0;
            sleep_reg       <= '0;
            load_reg        <= '0;
            use_reg         <= '0;
            prod_reg        <= '0;
            prio_reg        <= '0;
            div_started_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        func_reg   <= s_axis_tuser;
                        weight_reg <= s_axis_tdata[7:0];
                        est_reg    <= s_axis_tdata[15:8];
                        raw_reg    <= s_axis_tdata[23:16];
                        nice_reg   <= s_axis_tdata[29:24];
                        sleep_reg  <= s_axis_tdata[45:30];
                        load_reg   <= {load_avg_reg, 1'b0};
                        state_reg  <= (s_axis_tdata[7:0] == '0) ? ST_CHECK : ST_LF_DIV;
                    end
                end

                ST_LF_DIV:
                begin
                    state_reg <= ST_LF_WAIT;
                end

                ST_LF_WAIT:
                begin
                    // round the load factor down to a multiple of the weight
                    if (div_rsp.done)
                    begin
                        load_reg  <= load_reg - div_rsp.rem[cud_pkg::LOAD_W-1:0];
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    if (!func_reg)
                    begin
                        if (est_reg == '0)
                        begin
                            est_reg <= raw_reg;
                            use_reg <= raw_reg;
                        end
                        else
                        begin
                            use_reg <= est_reg;
                        end
                        state_reg <= ST_MUL;
                    end
                    else if ({{(cud_pkg::LOAD_W + 3 - cud_pkg::SLEEP_W){1'b0}}, sleep_reg}
                             > load_x5)
                    begin
                        est_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                    else if (sleep_reg <= cud_pkg::SLEEP_W'(1))
                    begin
                        sleep_reg <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        sleep_reg <= sleep_reg - 1'b1;
                        use_reg   <= est_reg;
                        state_reg <= ST_LOOP;
                    end
                end

                ST_LOOP:
                begin
                    if (use_reg == '0)
                    begin
                        est_reg   <= use_reg;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        sleep_reg <= sleep_reg - 1'b1;
                        if (sleep_reg == cud_pkg::SLEEP_W'(1))
                        begin
                            est_reg   <= use_reg;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end

                ST_MUL:
                begin
                    prod_reg        <= prod_calc;
                    div_started_reg <= 1'b0;
                    state_reg       <= ST_DIV;
                end

                ST_DIV:
                begin
                    div_started_reg <= 1'b1;
                    if (div_rsp.done)
                    begin
                        if (!func_reg)
                        begin
                            prio_reg  <= prio_val;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            use_reg   <= quot8;
                            state_reg <= ST_LOOP;
                        end
                    end
                end

                ST_DONE:
                begin
                    // hold the result until the output register is free
                    if (out_free)
                    begin
                        out_data_reg  <= {{cud_pkg::OUT_PAD_W{1'b0}}, sleep_reg, est_reg,
                                          func_reg ? {cud_pkg::PRIO_W{1'b0}} : prio_reg};
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/cud_checker.sv
// Port-level checks for the CPU usage decay block, bound to the top level.
module cud_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cud_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time: drop ready once a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_prio_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:0] <= 9'd286)
        else $error("priority value out of range");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[cud_pkg::OUT_DATA_W-1:33] == '0)
        else $error("padding bits not zero");

endmodule

bind cpu_usage_decay_top cud_checker u_cud_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
